FILE: rtl/assert_macros.svh
// Assertion helpers shared by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define LTQ_ASSERT(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Check that a trigger implies a condition in the same cycle.
`define LTQ_ASSERT_IMPL(lbl, clk, rst, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("assertion failed");

`endif

FILE: rtl/ltq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ltq_pkg
// Shared types, codes and the ordering function of the lossy packet queue.
// ---------------------------------------------------------------------------
package ltq_pkg;

  localparam int TIME_BITS  = 64;
  localparam int SEQ_BITS   = 32;
  localparam int RAND_BITS  = 32;
  localparam int LIMIT_BITS = 11;
  localparam int CFG_BITS   = 32;
  localparam int CFG_IDX_BITS = 3;
  localparam int STATUS_BITS  = 3;
  localparam logic [LIMIT_BITS-1:0] DEFAULT_LIMIT = 11'd1000;

  localparam logic [STATUS_BITS-1:0] ST_QUEUED   = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_LOST     = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_DEQUEUED = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 3'd4;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MOVE_TO_BAD  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MOVE_TO_GOOD = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KEEP_BAD     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOSS_GOOD    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_QUEUE_LIMIT  = 3'd4;

  localparam logic FUNC_ENQUEUE = 1'b0;

  typedef enum logic [1:0] {
    OP_REPORT,
    OP_INSERT,
    OP_REMOVE
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [STATUS_BITS-1:0] status;
  } cmd_ctl_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_INS,
    B_UP,
    B_UP_CMP,
    B_RM_ROOT,
    B_RM_LAST,
    B_RM_TAKE,
    B_DN_L,
    B_DN_R,
    B_DN_CMP,
    B_OUT
  } back_state_t;

  // Earlier timestamp first; equal timestamps by arrival sequence (wrapping).
  function automatic logic key_less(input logic [TIME_BITS-1:0] ta,
                                    input logic [SEQ_BITS-1:0]  sa,
                                    input logic [TIME_BITS-1:0] tb,
                                    input logic [SEQ_BITS-1:0]  sb);
    logic [SEQ_BITS-1:0] diff;
    diff = sa - sb;
    return (ta < tb) || ((ta == tb) && diff[SEQ_BITS-1]);
  endfunction

endpackage

FILE: rtl/ltq_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ltq_in_if / ltq_out_if
// Valid/ready channels carrying queue requests and queue results.
// ---------------------------------------------------------------------------
interface ltq_in_if #(
  parameter int HANDLE_BITS = 16
) ();
  logic                             valid;
  logic                             ready;
  logic                             func;
  logic [HANDLE_BITS-1:0]           packet_handle;
  logic [ltq_pkg::TIME_BITS-1:0]    arrival_time;
  logic [ltq_pkg::RAND_BITS-1:0]    rand_move;
  logic [ltq_pkg::RAND_BITS-1:0]    rand_loss;

  modport source (output valid, func, packet_handle, arrival_time, rand_move, rand_loss,
                  input ready);
  modport sink (input valid, func, packet_handle, arrival_time, rand_move, rand_loss,
                output ready);
endinterface

interface ltq_out_if #(
  parameter int HANDLE_BITS = 16
) ();
  logic                             valid;
  logic                             ready;
  logic [ltq_pkg::STATUS_BITS-1:0]  status;
  logic [HANDLE_BITS-1:0]           out_handle;
  logic [ltq_pkg::TIME_BITS-1:0]    out_time;

  modport source (output valid, status, out_handle, out_time, input ready);
  modport sink (input valid, status, out_handle, out_time, output ready);
endinterface

FILE: rtl/ltq_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ltq_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module ltq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/ltq_cmd_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ltq_cmd_fifo
// Four-entry command queue between classification and heap engine.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ltq_cmd_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;

  assign full      = (count == (PW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `LTQ_ASSERT_IMPL(a_no_overflow, clk, rst, push, !full)
  `LTQ_ASSERT_IMPL(a_no_underflow, clk, rst, pop, not_empty)
  `LTQ_ASSERT(a_count_bound, clk, rst, count <= (PW+1)'(DEPTH))

endmodule

FILE: rtl/ltq_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ltq_front
// Configuration, loss model and admission; classifies each request.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ltq_front #(
  parameter int QUEUE_DEPTH = 1024,
  parameter int HANDLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ltq_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [ltq_pkg::CFG_BITS-1:0]        cfg_data,
  ltq_in_if.sink                              in_ch,
  input  logic                                fifo_full,
  output logic                                push,
  output ltq_pkg::cmd_ctl_t                   push_ctl,
  output logic [HANDLE_BITS-1:0]              push_handle,
  output logic [ltq_pkg::TIME_BITS-1:0]       push_time,
  output logic [ltq_pkg::SEQ_BITS-1:0]        push_seq
);

  localparam int OW = $clog2(QUEUE_DEPTH + 1);
  localparam int CW = (OW > ltq_pkg::LIMIT_BITS) ? OW : ltq_pkg::LIMIT_BITS;

  logic [ltq_pkg::RAND_BITS-1:0]  move_to_bad;
  logic [ltq_pkg::RAND_BITS-1:0]  move_to_good;
  logic [ltq_pkg::RAND_BITS-1:0]  keep_bad;
  logic [ltq_pkg::RAND_BITS-1:0]  loss_good;
  logic [ltq_pkg::LIMIT_BITS-1:0] queue_limit;
  logic                           channel_bad;
  logic [OW-1:0]                  occupancy;
  logic [ltq_pkg::SEQ_BITS-1:0]   arrival_sequence;

  logic          accept;
  logic          lost;
  logic          move;
  logic [CW-1:0] cap;
  logic          is_full;

  assign in_ch.ready = !fifo_full;
  assign accept      = in_ch.valid && !fifo_full;

  always_comb begin
    if (CW'(queue_limit) > CW'(QUEUE_DEPTH)) begin
      cap = CW'(QUEUE_DEPTH);
    end else begin
      cap = CW'(queue_limit);
    end
    is_full = (CW'(occupancy) >= cap);
    if (!channel_bad) begin
      lost = (in_ch.rand_loss < loss_good);
      move = (in_ch.rand_move < move_to_bad);
    end else begin
      lost = (in_ch.rand_loss > keep_bad);
      move = (in_ch.rand_move < move_to_good);
    end
  end

  always_comb begin
    push_ctl.op     = ltq_pkg::OP_REPORT;
    push_ctl.status = ltq_pkg::ST_EMPTY;
    if (in_ch.func == ltq_pkg::FUNC_ENQUEUE) begin
      if (lost) begin
        push_ctl.status = ltq_pkg::ST_LOST;
      end else if (is_full) begin
        push_ctl.status = ltq_pkg::ST_FULL;
      end else begin
        push_ctl.op     = ltq_pkg::OP_INSERT;
        push_ctl.status = ltq_pkg::ST_QUEUED;
      end
    end else if (occupancy != '0) begin
      push_ctl.op     = ltq_pkg::OP_REMOVE;
      push_ctl.status = ltq_pkg::ST_DEQUEUED;
    end
  end

  assign push        = accept;
  assign push_handle = in_ch.packet_handle;
  assign push_time   = in_ch.arrival_time;
  assign push_seq    = arrival_sequence;

  always_ff @(posedge clk) begin
    if (rst) begin
      move_to_bad      <= '0;
      move_to_good     <= '0;
      keep_bad         <= '0;
      loss_good        <= '0;
      queue_limit      <= ltq_pkg::DEFAULT_LIMIT;
      channel_bad      <= 1'b0;
      occupancy        <= '0;
      arrival_sequence <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ltq_pkg::CFG_MOVE_TO_BAD:  move_to_bad  <= cfg_data;
          ltq_pkg::CFG_MOVE_TO_GOOD: move_to_good <= cfg_data;
          ltq_pkg::CFG_KEEP_BAD:     keep_bad     <= cfg_data;
          ltq_pkg::CFG_LOSS_GOOD:    loss_good    <= cfg_data;
          ltq_pkg::CFG_QUEUE_LIMIT:  queue_limit  <= cfg_data[ltq_pkg::LIMIT_BITS-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (in_ch.func == ltq_pkg::FUNC_ENQUEUE && move) begin
          channel_bad <= !channel_bad;
        end
        if (push_ctl.op == ltq_pkg::OP_INSERT) begin
          occupancy        <= occupancy + 1'b1;
          arrival_sequence <= arrival_sequence + 1'b1;
        end else if (push_ctl.op == ltq_pkg::OP_REMOVE) begin
          occupancy <= occupancy - 1'b1;
        end
      end
    end
  end

  `LTQ_ASSERT(a_occ_bound, clk, rst, occupancy <= OW'(QUEUE_DEPTH))
  `LTQ_ASSERT_IMPL(a_no_empty_remove, clk, rst,
                   push && push_ctl.op == ltq_pkg::OP_REMOVE, occupancy != '0)

endmodule

FILE: rtl/ltq_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ltq_back
// Binary min-heap engine in RAM and the result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ltq_back #(
  parameter int QUEUE_DEPTH = 1024,
  parameter int HANDLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  ltq_pkg::cmd_ctl_t             cmd_ctl,
  input  logic [HANDLE_BITS-1:0]        cmd_handle,
  input  logic [ltq_pkg::TIME_BITS-1:0] cmd_time,
  input  logic [ltq_pkg::SEQ_BITS-1:0]  cmd_seq,
  output logic                          pop,
  ltq_out_if.source                     out_ch
);

  localparam int TB = ltq_pkg::TIME_BITS;
  localparam int SB = ltq_pkg::SEQ_BITS;
  localparam int EW = TB + SB + HANDLE_BITS;
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int OW = $clog2(QUEUE_DEPTH + 1);
  localparam int XW = AW + 2;

  ltq_pkg::back_state_t state, state_next;

  logic [OW-1:0]             size;
  logic [AW-1:0]             idx;
  logic [TB-1:0]             it_time;
  logic [SB-1:0]             it_seq;
  logic [HANDLE_BITS-1:0]    it_handle;
  logic [TB-1:0]             lc_time;
  logic [SB-1:0]             lc_seq;
  logic [HANDLE_BITS-1:0]    lc_handle;
  logic [AW-1:0]             lc_idx;
  logic                      has_r;
  logic [ltq_pkg::STATUS_BITS-1:0] res_status;
  logic [HANDLE_BITS-1:0]    res_handle;
  logic [TB-1:0]             res_time;
  logic                      ov;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [EW-1:0]             ram_wdata;
  logic                      ram_re;
  logic [AW-1:0]             ram_raddr;
  logic [EW-1:0]             ram_rdata;

  logic [TB-1:0]             rd_time;
  logic [SB-1:0]             rd_seq;
  logic [HANDLE_BITS-1:0]    rd_handle;
  logic [XW-1:0]             l_pos;
  logic [XW-1:0]             r_pos;
  logic [AW-1:0]             parent;
  logic                      l_ok;
  logic                      r_ok;
  logic                      pick_r;
  logic                      up_swap;
  logic                      dn_swap;
  logic [TB-1:0]             ch_time;
  logic [SB-1:0]             ch_seq;
  logic [AW-1:0]             ch_idx;
  logic                      out_free;

  ltq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_heap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_time   = ram_rdata[EW-1 -: TB];
  assign rd_seq    = ram_rdata[HANDLE_BITS +: SB];
  assign rd_handle = ram_rdata[HANDLE_BITS-1:0];

  assign l_pos  = {1'b0, idx, 1'b1};
  assign r_pos  = l_pos + 1'b1;
  assign l_ok   = l_pos < XW'(size);
  assign r_ok   = r_pos < XW'(size);
  assign parent = (idx - 1'b1) >> 1;

  assign pick_r  = has_r && ltq_pkg::key_less(rd_time, rd_seq, lc_time, lc_seq);
  assign ch_time = pick_r ? rd_time : lc_time;
  assign ch_seq  = pick_r ? rd_seq : lc_seq;
  assign ch_idx  = pick_r ? (lc_idx + 1'b1) : lc_idx;
  assign dn_swap = ltq_pkg::key_less(ch_time, ch_seq, it_time, it_seq);
  assign up_swap = ltq_pkg::key_less(it_time, it_seq, rd_time, rd_seq);
  assign out_free = !ov || out_ch.ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ltq_pkg::B_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd_ctl.op)
            ltq_pkg::OP_INSERT: state_next = ltq_pkg::B_INS;
            ltq_pkg::OP_REMOVE: state_next = ltq_pkg::B_RM_ROOT;
            default:            state_next = ltq_pkg::B_OUT;
          endcase
        end
      end
      ltq_pkg::B_INS:     state_next = ltq_pkg::B_UP;
      ltq_pkg::B_UP:      state_next = (idx == '0) ? ltq_pkg::B_OUT : ltq_pkg::B_UP_CMP;
      ltq_pkg::B_UP_CMP:  state_next = up_swap ? ltq_pkg::B_UP : ltq_pkg::B_OUT;
      ltq_pkg::B_RM_ROOT: state_next = ltq_pkg::B_RM_LAST;
      ltq_pkg::B_RM_LAST: state_next = ltq_pkg::B_RM_TAKE;
      ltq_pkg::B_RM_TAKE: state_next = (size == '0) ? ltq_pkg::B_OUT : ltq_pkg::B_DN_L;
      ltq_pkg::B_DN_L:    state_next = l_ok ? ltq_pkg::B_DN_R : ltq_pkg::B_OUT;
      ltq_pkg::B_DN_R:    state_next = ltq_pkg::B_DN_CMP;
      ltq_pkg::B_DN_CMP:  state_next = dn_swap ? ltq_pkg::B_DN_L : ltq_pkg::B_OUT;
      ltq_pkg::B_OUT:     state_next = out_free ? ltq_pkg::B_IDLE : ltq_pkg::B_OUT;
      default:            state_next = ltq_pkg::B_IDLE;
    endcase
  end

  // RAM control and command pop
  always_comb begin
    pop       = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = {it_time, it_seq, it_handle};
    ram_re    = 1'b0;
    ram_raddr = parent;
    unique case (state)
      ltq_pkg::B_IDLE: pop = cmd_valid;
      ltq_pkg::B_UP: begin
        if (idx == '0) begin
          ram_we = 1'b1;
        end else begin
          ram_re = 1'b1;
        end
      end
      ltq_pkg::B_UP_CMP: begin
        ram_we = 1'b1;
        if (up_swap) begin
          ram_wdata = ram_rdata;
        end
      end
      ltq_pkg::B_RM_ROOT: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      ltq_pkg::B_RM_LAST: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(size - 1'b1);
      end
      ltq_pkg::B_DN_L: begin
        if (l_ok) begin
          ram_re    = 1'b1;
          ram_raddr = l_pos[AW-1:0];
        end else begin
          ram_we = 1'b1;
        end
      end
      ltq_pkg::B_DN_R: begin
        ram_re    = r_ok;
        ram_raddr = r_pos[AW-1:0];
      end
      ltq_pkg::B_DN_CMP: begin
        ram_we = 1'b1;
        if (dn_swap) begin
          ram_wdata = pick_r ? ram_rdata : {lc_time, lc_seq, lc_handle};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ltq_pkg::B_IDLE;
      size  <= '0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ltq_pkg::B_INS) begin
        size <= size + 1'b1;
      end else if (state == ltq_pkg::B_RM_LAST) begin
        size <= size - 1'b1;
      end
      if (state == ltq_pkg::B_OUT && out_free) begin
        ov <= 1'b1;
      end else if (out_ch.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ltq_pkg::B_IDLE: begin
        if (cmd_valid) begin
          it_time    <= cmd_time;
          it_seq     <= cmd_seq;
          it_handle  <= cmd_handle;
          res_status <= cmd_ctl.status;
          res_handle <= '0;
          res_time   <= '0;
        end
      end
      ltq_pkg::B_INS:    idx <= AW'(size);
      ltq_pkg::B_UP_CMP: begin
        if (up_swap) begin
          idx <= parent;
        end
      end
      ltq_pkg::B_RM_LAST: begin
        res_handle <= rd_handle;
        res_time   <= rd_time;
      end
      ltq_pkg::B_RM_TAKE: begin
        it_time   <= rd_time;
        it_seq    <= rd_seq;
        it_handle <= rd_handle;
        idx       <= '0;
      end
      ltq_pkg::B_DN_R: begin
        lc_time   <= rd_time;
        lc_seq    <= rd_seq;
        lc_handle <= rd_handle;
        lc_idx    <= l_pos[AW-1:0];
        has_r     <= r_ok;
      end
      ltq_pkg::B_DN_CMP: begin
        if (dn_swap) begin
          idx <= ch_idx;
        end
      end
      default: ;
    endcase
    if (state == ltq_pkg::B_OUT && out_free) begin
      out_ch.status     <= res_status;
      out_ch.out_handle <= res_handle;
      out_ch.out_time   <= res_time;
    end
  end

  assign out_ch.valid = ov;

  `LTQ_ASSERT(a_size_bound, clk, rst, size <= OW'(QUEUE_DEPTH))
  `LTQ_ASSERT_IMPL(a_remove_nonempty, clk, rst,
                   pop && cmd_ctl.op == ltq_pkg::OP_REMOVE, size != '0)

endmodule

FILE: rtl/lossy_timestamp_ordered_packet_queue_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lossy_timestamp_ordered_packet_queue_top
// Network emulator queue: loss model, admission and time-ordered release.
// ---------------------------------------------------------------------------
//
//   port     | dir  | carries
//   ---------+------+---------------------------------------------------------
//   in_ch    | sink | func, packet_handle, arrival_time, rand_move, rand_loss
//   out_ch   | src  | status, out_handle, out_time
//   cfg_*    | in   | register writes: index 0..4, 32-bit data, no wait
//
// Steps, from the input transfer to the result being presented: a lost,
//   refused or empty request goes from the command queue to the result
//   register; an enqueue starts at the end of the heap and climbs, reading
//   the parent and comparing at each level; a dequeue reads the root and the
//   last entry, then descends, reading both children and comparing per level.
//   The single read and single write port of the heap RAM sets this order.
// Reset: synchronous, active high; clears the loss state, counts, the command
//   queue and the result valid flag. The heap RAM needs no clearing.
// Stalls: the classifier keeps taking requests while the four-entry command
//   queue has room; the result register holds a transfer until out_ch takes it.
// ---------------------------------------------------------------------------
module lossy_timestamp_ordered_packet_queue_top #(
  parameter int QUEUE_DEPTH = 1024,
  parameter int HANDLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ltq_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ltq_pkg::CFG_BITS-1:0]     cfg_data,
  ltq_in_if.sink                           in_ch,
  ltq_out_if.source                        out_ch
);

  localparam int CTLW = $bits(ltq_pkg::cmd_ctl_t);
  localparam int TB   = ltq_pkg::TIME_BITS;
  localparam int SB   = ltq_pkg::SEQ_BITS;
  localparam int FW   = CTLW + HANDLE_BITS + TB + SB;

  // Front side: classified request.
  logic                   push;
  ltq_pkg::cmd_ctl_t      push_ctl;
  logic [HANDLE_BITS-1:0] push_handle;
  logic [TB-1:0]          push_time;
  logic [SB-1:0]          push_seq;
  logic                   fifo_full;

  // Back side: head of the command queue.
  logic                   pop;
  logic                   cmd_valid;
  logic [FW-1:0]          cmd_word;

  // Classify each request and apply the loss model.
  ltq_front #(.QUEUE_DEPTH(QUEUE_DEPTH), .HANDLE_BITS(HANDLE_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_ch       (in_ch),
    .fifo_full   (fifo_full),
    .push        (push),
    .push_ctl    (push_ctl),
    .push_handle (push_handle),
    .push_time   (push_time),
    .push_seq    (push_seq)
  );

  // Hold classified commands in order between the two sides.
  ltq_cmd_fifo #(.WIDTH(FW)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_ctl, push_handle, push_time, push_seq}),
    .full      (fifo_full),
    .pop       (pop),
    .not_empty (cmd_valid),
    .pop_data  (cmd_word)
  );

  // Run heap insert and removal, then present the result.
  ltq_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .HANDLE_BITS(HANDLE_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ctl    (ltq_pkg::cmd_ctl_t'(cmd_word[FW-1 -: CTLW])),
    .cmd_handle (cmd_word[TB+SB +: HANDLE_BITS]),
    .cmd_time   (cmd_word[SB +: TB]),
    .cmd_seq    (cmd_word[SB-1:0]),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
